// File: sv/spr_pkg.sv
// Shared types, constants and register codes for the stream pattern replacer.
package spr_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int LEN_W = 5;
	localparam int CNT_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;
	localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		REG_PLEN = 3'd0,
		REG_PLO  = 3'd1,
		REG_PHI  = 3'd2,
		REG_RLO  = 3'd3,
		REG_RHI  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_REPL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic        from_replacement;
		logic [31:0] match_total;
	} out_word_t;

	typedef struct packed {
		logic [LEN_W-1:0]             len;
		logic [MAX_PATTERN-1:0][7:0] pattern;
		logic [MAX_PATTERN-1:0][7:0] replacement;
	} cfg_t;

endpackage

// File: sv/stream_pattern_replace.sv
// Top level of the stream pattern replacer: window cells, sequencer and output queue.
//
//   port group  dir  handshake            word
//   in_*        in   in_valid / in_stall   in_word (in_byte, in_last)
//   out_*       out  out_valid / out_stall out_word (out_byte, out_last, from_replacement,
//                                           match_total)
//   p*          in   APB write/read        64-bit registers at byte address 8*index
//
// While the queue has room, a byte that gives at most one word is taken every cycle; a
// match of length L holds the input while the rest of the replacement leaves one word per
// cycle, and the last byte of a stream holds it while pending window bytes drain.
// Each word is registered in a two-entry queue and leaves from there on out_word.
// Window cells and queue entries hold no reset; all other registers are cleared.
// An output stall is absorbed by the queue, so one more byte is taken while a word waits.
module stream_pattern_replace (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  spr_pkg::in_word_t          in_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output spr_pkg::out_word_t         out_word,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spr_pkg::ADDR_W-1:0] paddr,
	input  logic [spr_pkg::DATA_W-1:0] pwdata,
	output logic [spr_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import spr_pkg::*;

	cfg_t             cfg;
	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_d;
	logic             last_q;
	logic             last_d;
	logic [31:0]      total_q;
	logic [31:0]      total_d;
	logic [31:0]      total_inc;
	logic [7:0]       view [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq;
	logic [MAX_PATTERN-1:0] mask;
	logic [MAX_PATTERN-1:0] occupied;
	logic [LEN_W-1:0] count_p1;
	logic             room;
	logic             accept;
	logic             matched;
	logic             win_full;
	logic             shift;
	logic             push;
	out_word_t        push_word;

	spr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [7:0] nbr;

		if (i == MAX_PATTERN - 1) begin : g_end
			assign nbr = in_word.in_byte;
		end else begin : g_mid
			assign nbr = view[i+1];
		end

		assign occupied[i] = (count_q > CNT_W'(i));
		assign mask[i]     = (LEN_W'(i) < cfg.len);

		spr_cell u_cell (
			.clk      (clk),
			.occupied (occupied[i]),
			.shift    (shift),
			.in_byte  (in_word.in_byte),
			.nbr      (nbr),
			.pat_byte (cfg.pattern[i]),
			.view     (view[i]),
			.eq       (eq[i])
		);
	end

	assign in_stall  = (state_q != ST_RUN) | ~room;
	assign accept    = in_valid & ~in_stall;
	assign count_p1  = LEN_W'(count_q) + LEN_W'(1);
	assign matched   = (cfg.len != '0) && (count_p1 >= cfg.len) && (&(eq | ~mask));
	assign win_full  = (cfg.len == '0) || (count_p1 >= cfg.len);
	assign total_inc = (total_q == TOTAL_MAX) ? total_q : total_q + 32'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (accept && matched && cfg.len != LEN_W'(1)) begin
					state_d = ST_REPL;
				end else if (accept && in_word.in_last && count_q != '0) begin
					state_d = ST_FLUSH;
				end
			end
			ST_REPL: begin
				if (room && (LEN_W'(k_q) + LEN_W'(1) == cfg.len)) begin
					state_d = (last_q && count_q != CNT_W'(1)) ? ST_FLUSH : ST_RUN;
				end
			end
			ST_FLUSH: begin
				if (room && count_q == CNT_W'(1)) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		push      = 1'b0;
		shift     = 1'b0;
		push_word = '0;
		count_d   = count_q;
		k_d       = k_q;
		last_d    = last_q;
		total_d   = total_q;
		unique case (state_q)
			ST_RUN: begin
				if (accept) begin
					last_d = in_word.in_last;
					if (matched) begin
						push                       = 1'b1;
						shift                      = 1'b1;
						push_word.out_byte         = cfg.replacement[0];
						push_word.from_replacement = 1'b1;
						push_word.match_total      = total_inc;
						total_d                    = total_inc;
						k_d                        = CNT_W'(1);
						if (cfg.len == LEN_W'(1) && in_word.in_last && count_q == '0) begin
							push_word.out_last = 1'b1;
							total_d            = '0;
						end
					end else if (win_full || in_word.in_last) begin
						push                  = 1'b1;
						shift                 = 1'b1;
						push_word.out_byte    = view[0];
						push_word.match_total = total_q;
						if (in_word.in_last && count_q == '0) begin
							push_word.out_last = 1'b1;
							total_d            = '0;
						end
					end else begin
						count_d = CNT_W'(count_p1);
					end
				end
			end
			ST_REPL: begin
				if (room) begin
					push                       = 1'b1;
					shift                      = 1'b1;
					push_word.out_byte         = cfg.replacement[k_q];
					push_word.from_replacement = 1'b1;
					push_word.match_total      = total_q;
					count_d                    = count_q - CNT_W'(1);
					k_d                        = k_q + CNT_W'(1);
					if ((LEN_W'(k_q) + LEN_W'(1) == cfg.len) && last_q
							&& count_q == CNT_W'(1)) begin
						push_word.out_last = 1'b1;
						total_d            = '0;
					end
				end
			end
			ST_FLUSH: begin
				if (room) begin
					push                  = 1'b1;
					shift                 = 1'b1;
					push_word.out_byte    = view[0];
					push_word.match_total = total_q;
					count_d               = count_q - CNT_W'(1);
					if (count_q == CNT_W'(1)) begin
						push_word.out_last = 1'b1;
						total_d            = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			count_q <= '0;
			k_q     <= '0;
			last_q  <= 1'b0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
			last_q  <= last_d;
			total_q <= total_d;
		end
	end

	spr_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// File: sv/spr_cell.sv
// One window cell: holds a pending byte, compares it, and shifts toward the oldest end.
module spr_cell (
	input  logic       clk,
	input  logic       occupied,
	input  logic       shift,
	input  logic [7:0] in_byte,
	input  logic [7:0] nbr,
	input  logic [7:0] pat_byte,
	output logic [7:0] view,
	output logic       eq
);

	logic [7:0] byte_q;

	assign view = occupied ? byte_q : in_byte;
	assign eq   = (view == pat_byte);

	always_ff @(posedge clk) begin
		byte_q <= shift ? nbr : view;
	end

endmodule

// File: sv/spr_ofifo.sv
// Two-entry output queue that decouples the window logic from output stalls.
module spr_ofifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  spr_pkg::out_word_t push_word,
	output logic               room,
	output logic               out_valid,
	input  logic               out_stall,
	output spr_pkg::out_word_t out_word
);
	import spr_pkg::*;

	out_word_t  mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign room      = (cnt_q != 2'd2);
	assign out_word  = mem_q[rd_q];
	assign pop       = out_valid & ~out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: sv/spr_cfg.sv
// APB register bank holding pattern length, pattern and replacement bytes.
module spr_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spr_pkg::ADDR_W-1:0] paddr,
	input  logic [spr_pkg::DATA_W-1:0] pwdata,
	output logic [spr_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output spr_pkg::cfg_t              cfg
);
	import spr_pkg::*;

	logic [LEN_W-1:0]  plen_q;
	logic [DATA_W-1:0] plo_q;
	logic [DATA_W-1:0] phi_q;
	logic [DATA_W-1:0] rlo_q;
	logic [DATA_W-1:0] rhi_q;
	logic              wr;
	reg_idx_t          idx;
	logic [127:0]      pat_all;
	logic [127:0]      rep_all;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			plo_q  <= '0;
			phi_q  <= '0;
			rlo_q  <= '0;
			rhi_q  <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_PLEN: plen_q <= pwdata[LEN_W-1:0];
				REG_PLO:  plo_q  <= pwdata;
				REG_PHI:  phi_q  <= pwdata;
				REG_RLO:  rlo_q  <= pwdata;
				REG_RHI:  rhi_q  <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PLEN: prdata = DATA_W'(plen_q);
			REG_PLO:  prdata = plo_q;
			REG_PHI:  prdata = phi_q;
			REG_RLO:  prdata = rlo_q;
			REG_RHI:  prdata = rhi_q;
			default:  prdata = '0;
		endcase
	end

	assign pat_all = {phi_q, plo_q};
	assign rep_all = {rhi_q, rlo_q};

	always_comb begin
		cfg.len = (plen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_q;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			cfg.pattern[i]     = pat_all[8*i +: 8];
			cfg.replacement[i] = rep_all[8*i +: 8];
		end
	end

endmodule

// File: sv/spr_checker.sv
// Port-level checks for the stream pattern replacer, bound to the top level.
module spr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input spr_pkg::out_word_t out_word
);
	import spr_pkg::*;

	logic        out_acc;
	logic        mid_q;
	logic [31:0] prev_total_q;

	assign out_acc = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
		end else if (out_acc) begin
			mid_q <= ~out_word.out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_total_q <= out_word.match_total;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	a_rep_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.from_replacement |-> out_word.match_total != 32'd0)
		else $error("replacement word with zero match total");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && mid_q |-> (out_word.match_total >= prev_total_q)
			&& (out_word.match_total - prev_total_q <= 32'd1))
		else $error("match total jumped within a stream");

	a_total_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !mid_q |-> out_word.match_total <= 32'd1)
		else $error("match total did not restart with the stream");

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for stream_pattern_replace with its own search-and-replace predictor.
module tb_top;
	import spr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN = 40;
	localparam int BYTE_TARGET = 280;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic [LEN_W-1:0] cur_len = '0;
	logic [MAX_PATTERN-1:0][7:0] cur_pat = '0;
	logic [MAX_PATTERN-1:0][7:0] cur_rep = '0;
	logic [7:0] window [MAX_PATTERN];
	int fill = 0;
	logic [31:0] tally = '0;

	in_word_t byte_queue[$];
	out_word_t patched_q[$];
	int pushed = 0;
	int streams = 0;
	int words_checked = 0;
	int replacements = 0;
	int errors = 0;
	int quiet = 0;
	int idle_pct = 0;
	int phases = 0;
	int send_gap = 0;
	int stall_left = 0;

	stream_pattern_replace i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (errors < 30)
			$display("mismatch at word %0d: %s got %0h expected %0h", words_checked, what, got,
				want);
		errors++;
	endtask

	task automatic patch_byte(input in_word_t w);
		out_word_t res [MAX_PATTERN];
		int len;
		int win;
		int n;
		int d;
		bit hit;
		len = (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);
		win = (len == 0) ? 1 : len;
		n = 0;
		d = 0;
		if (fill < MAX_PATTERN) begin
			window[fill] = w.in_byte;
			fill++;
		end
		hit = (len > 0) && (fill >= len);
		for (int k = 0; k < len; k++)
			if (hit && window[k] != cur_pat[k])
				hit = 1'b0;
		if (hit) begin
			if (tally != TOTAL_MAX)
				tally++;
			replacements++;
			for (int k = 0; k < len; k++) begin
				res[n] = '{cur_rep[k], 1'b0, 1'b1, tally};
				n++;
			end
			d = len;
		end else if (fill >= win) begin
			res[n] = '{window[0], 1'b0, 1'b0, tally};
			n++;
			d = 1;
		end
		for (int k = 0; k + d < fill; k++)
			window[k] = window[k + d];
		fill = (fill > d) ? fill - d : 0;
		if (w.in_last) begin
			for (int k = 0; k < fill && n < MAX_PATTERN; k++) begin
				res[n] = '{window[k], 1'b0, 1'b0, tally};
				n++;
			end
			fill = 0;
			if (n > 0)
				res[n - 1].out_last = 1'b1;
			tally = '0;
		end
		for (int k = 0; k < n; k++)
			patched_q.insert(patched_q.size(), res[k]);
	endtask

	task automatic check_word(input out_word_t got);
		out_word_t want;
		if (patched_q.size() == 0) begin
			report("word with nothing expected, out_byte", 32'(got.out_byte), '0);
		end else begin
			want = patched_q.pop_front();
			words_checked++;
			if (got.out_byte != want.out_byte)
				report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
			if (got.out_last != want.out_last)
				report("out_last", 32'(got.out_last), 32'(want.out_last));
			if (got.from_replacement != want.from_replacement)
				report("from_replacement", 32'(got.from_replacement),
					32'(want.from_replacement));
			if (got.match_total != want.match_total)
				report("match_total", got.match_total, want.match_total);
		end
	endtask

	// Input side: one word per handshake, random bursts of idle cycles between words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				void'(byte_queue.pop_front());
			if (!(in_valid && in_stall)) begin
				if (idle_pct > 0 && send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
					in_valid <= 1'b0;
					send_gap = $urandom_range(0, 5);
				end else if (byte_queue.size() > 0) begin
					in_valid <= 1'b1;
					in_word <= byte_queue[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Predicts from accepted input words, then checks output words; also drives out_stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			quiet <= 0;
		end else begin
			if (in_valid && !in_stall)
				patch_byte(in_word);
			if (out_valid && !out_stall)
				check_word(out_word);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (idle_pct > 0 && stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 5);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PLEN: cur_len = value[LEN_W-1:0];
			REG_PLO: cur_pat[7:0] = value;
			REG_PHI: cur_pat[15:8] = value;
			REG_RLO: cur_rep[7:0] = value;
			REG_RHI: cur_rep[15:8] = value;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (byte_queue.size() != 0 || in_valid || patched_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b, input bit last);
		in_word_t w;
		w.in_byte = b;
		w.in_last = last;
		byte_queue.insert(byte_queue.size(), w);
		pushed++;
	endtask

	// Builds a stream from planted patterns, broken prefixes and filler bytes.
	task automatic add_stream(input int nbytes, input bit close);
		int len;
		int pick;
		int cut;
		len = (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);
		while (nbytes > 0) begin
			pick = $urandom_range(0, 9);
			if (len > 0 && pick < 4)
				cut = len;
			else if (len > 1 && pick < 6)
				cut = $urandom_range(1, len - 1);
			else
				cut = 0;
			for (int k = 0; k < cut; k++)
				push_byte(cur_pat[k], 1'b0);
			nbytes -= cut;
			if (!(cut == len && pick == 0)) begin
				if (len > 0 && pick[0])
					push_byte(cur_pat[$urandom_range(0, len - 1)], 1'b0);
				else
					push_byte(8'($urandom_range(0, 255)), 1'b0);
				nbytes--;
			end
		end
		byte_queue[byte_queue.size() - 1].in_last = close;
		if (close)
			streams++;
	endtask

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [7:0] abc_run [10];
		logic [MAX_PATTERN-1:0][7:0] new_pat;
		logic [4:0] plen;
		int mode;
		int nstreams;
		int len;
		int nb;
		bit close;
		bit open_stream;
		abc_run = '{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62};
		close = 1'b1;
		open_stream = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Length zero after reset passes every byte straight through.
		@(negedge clk);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b1);
		streams++;
		wait_idle();

		// A match, a broken prefix, a match, then a stream shorter than the pattern.
		write_reg(REG_PLEN, 64'd3);
		write_reg(REG_PLO, 64'h0000_0000_0063_6261);
		write_reg(REG_RLO, 64'h0000_0000_005A_5958);
		@(negedge clk);
		foreach (abc_run[k])
			push_byte(abc_run[k], k == 7 || k == 9);
		streams += 2;

		while (pushed < BYTE_TARGET) begin
			wait_idle();
			if (pushed > BYTE_TARGET - 60) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			end
			if (open_stream && $urandom_range(0, 1)) begin
				write_reg(REG_PLEN, 64'($urandom_range(0, 31)));
			end else begin
				case (phases)
					0: plen = 5'd16;
					1: plen = 5'd31;
					2: plen = 5'd1;
					3: plen = 5'd17;
					default: begin
						if ($urandom_range(0, 3) == 0)
							plen = 5'($urandom_range(0, 31));
						else
							plen = 5'($urandom_range(0, 6));
					end
				endcase
				mode = $urandom_range(0, 3);
				for (int k = 0; k < MAX_PATTERN; k++) begin
					case (mode)
						0: new_pat[k] = 8'($urandom_range(0, 255));
						1: new_pat[k] = 8'h00;
						2: new_pat[k] = 8'hFF;
						default: new_pat[k] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
					endcase
				end
				write_reg(REG_PLEN, 64'(plen));
				write_reg(REG_PLO, new_pat[7:0]);
				write_reg(REG_PHI, new_pat[15:8]);
				write_reg(REG_RLO, {$urandom, $urandom});
				write_reg(REG_RHI, {$urandom, $urandom});
			end
			phases++;
			@(negedge clk);
			len = (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);
			nstreams = $urandom_range(1, 3);
			for (int s = 0; s < nstreams; s++) begin
				close = (s < nstreams - 1) || ($urandom_range(0, 3) != 0);
				nb = $urandom_range(1, 2 * len + 8);
				if (pushed + nb > BYTE_TARGET)
					nb = (pushed < BYTE_TARGET) ? BYTE_TARGET - pushed : 1;
				add_stream(nb, close);
			end
			open_stream = !close;
		end

		if (open_stream) begin
			wait_idle();
			idle_pct = 0;
			add_stream(2, 1'b1);
		end
		wait_idle();

		$display("Summary: %0d bytes in %0d streams over %0d register settings, lengths 0 to 31.",
			pushed, streams, phases + 2);
		$display("Summary: %0d words checked, %0d replacements, %0d mismatches.", words_checked,
			replacements, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
